// ----- rtl/core/ic2d_pkg.sv -----
// Shared types, constants and helpers of the 2D image convolution block.
// Depends on nothing; every module of the block but ic2d_ram imports it.
package ic2d_pkg;

    localparam int IMAGE_WIDTH     = 1920;
    localparam int IMAGE_HEIGHT    = 1080;
    localparam int MAX_KERNEL_SIDE = 7;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 9;
    localparam int PROD_W     = PIX_W + COEF_W + 1;
    localparam int ROW_SUM_W  = PROD_W + 3;
    localparam int SUM_W      = 23;
    localparam int COORD_W    = 11;
    localparam int KSIZE_W    = 3;
    localparam int COL_W      = $clog2(IMAGE_WIDTH);
    localparam int ROW_W      = $clog2(IMAGE_HEIGHT);
    localparam int LINE_ROWS  = MAX_KERNEL_SIDE - 1;
    localparam int LINE_W     = LINE_ROWS * PIX_W;

    // Configuration register map.
    localparam int NUM_ROW_REGS = 7;
    localparam int KROW_COEFS   = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = KROW_COEFS * COEF_W;
    localparam logic [CFG_IDX_W-1:0] CFG_KSIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0  = 3'd1;
    localparam logic [KSIZE_W-1:0]   KSIZE_RESET = 3'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] filtered_value;
        logic [COORD_W-1:0]      centre_column;
        logic [COORD_W-1:0]      centre_row;
        logic                    frame_last;
    } t_out_item;

    typedef logic [KROW_COEFS-1:0][COEF_W-1:0] t_krow;

    typedef struct packed {
        logic [KSIZE_W-1:0]           ksize;
        t_krow [NUM_ROW_REGS-1:0]     rows;
    } t_cfg;

    typedef logic [MAX_KERNEL_SIDE-1:0][MAX_KERNEL_SIDE-1:0][PIX_W-1:0] t_window;
    typedef logic [LINE_ROWS-1:0][PIX_W-1:0] t_lines;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic               last;
    } t_meta;

    // Window handed from the window stage to the multiply-accumulate stages.
    typedef struct packed {
        logic    valid;
        t_meta   meta;
        t_window win;
    } t_win_item;

    // A kernel size of zero acts as one, an oversized one as the largest.
    function automatic logic [KSIZE_W-1:0] k_eff(input logic [KSIZE_W-1:0] ks);
        logic [KSIZE_W-1:0] k;
        k = ks;
        if (ks == '0) begin
            k = KSIZE_W'(1);
        end else if (ks > KSIZE_W'(MAX_KERNEL_SIDE)) begin
            k = KSIZE_W'(MAX_KERNEL_SIDE);
        end
        return k;
    endfunction

endpackage

// ----- rtl/core/ic2d_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ic2d_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ic2d_cfg.sv -----
// Configuration register file: kernel size and seven packed kernel rows.
// Depends on ic2d_pkg.
module ic2d_cfg import ic2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    logic [KSIZE_W-1:0]       r_ksize;
    t_krow [NUM_ROW_REGS-1:0] r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize <= KSIZE_RESET;
            r_rows  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_KSIZE) begin
                r_ksize <= i_cfg_data[KSIZE_W-1:0];
            end else begin
                r_rows[i_cfg_index - CFG_ROW0] <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = '{ksize: r_ksize, rows: r_rows};

endmodule

// ----- rtl/core/ic2d_window.sv -----
// Raster position, line store and pixel window; decides which pixels give a result.
// Depends on ic2d_pkg and ic2d_ram.
module ic2d_window import ic2d_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_in_item           i_item,
    output logic               o_stall,
    input  logic [KSIZE_W-1:0] i_ksize,
    output t_win_item          o_s2,
    input  logic               i_mac_ready
);

    localparam int XW = COL_W + 1;
    localparam int YW = ROW_W + 1;

    logic [COL_W-1:0] r_col, n_col, x0;
    logic [ROW_W-1:0] r_row, n_row, y0;

    logic             r_v1;
    logic [COL_W-1:0] r_x1;
    logic [ROW_W-1:0] r_y1;
    logic [PIX_W-1:0] r_px1;
    logic             r_byp;
    t_lines           r_byp_data;

    logic    r_v2;
    t_meta   r_meta2;
    t_window r_win;

    logic    rdy1, rdy2, accept, en1;
    t_lines  ram_rdata, lines_old, lines_new;
    t_window n_win;
    t_meta   n_meta;
    logic    has_res;

    logic [KSIZE_W-1:0] k, off, hi;
    logic [XW-1:0]      tx;
    logic [YW-1:0]      ty;
    logic [COL_W-1:0]   cx;
    logic [ROW_W-1:0]   cy;

    assign rdy2   = !r_v2 || i_mac_ready;
    assign rdy1   = !r_v1 || rdy2;
    assign en1    = r_v1 && rdy2;
    assign accept = i_valid && rdy1;
    assign o_stall = !rdy1;

    // Position of the incoming pixel and of the one after it.
    always_comb begin
        x0 = i_item.frame_start ? '0 : r_col;
        y0 = i_item.frame_start ? '0 : r_row;
        if (x0 == COL_W'(IMAGE_WIDTH - 1)) begin
            n_col = '0;
            n_row = (y0 == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : y0 + ROW_W'(1);
        end else begin
            n_col = x0 + COL_W'(1);
            n_row = y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (rdy1) begin
                r_v1 <= i_valid;
            end
        end
    end

    // A pixel read back at the column that the previous pixel writes in the
    // same cycle takes the written data instead of the stale RAM word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x1       <= x0;
            r_y1       <= y0;
            r_px1      <= i_item.pixel_value;
            r_byp      <= en1 && (r_x1 == x0);
            r_byp_data <= lines_new;
        end
    end

    ic2d_ram #(
        .WIDTH (LINE_W),
        .DEPTH (IMAGE_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (en1),
        .i_waddr (r_x1),
        .i_wdata (lines_new),
        .i_re    (accept),
        .i_raddr (x0),
        .o_rdata (ram_rdata)
    );

    // Column update: each line row moves down by one and the pixel enters row 0; the window shifts left by one column.
    always_comb begin
        lines_old = r_byp ? r_byp_data : ram_rdata;
        lines_new = {lines_old[LINE_ROWS-2:0], r_px1};
        for (int r = 0; r < MAX_KERNEL_SIDE; r++) begin
            for (int c = 0; c < MAX_KERNEL_SIDE - 1; c++) begin
                n_win[r][c] = r_win[r][c+1];
            end
        end
        for (int r = 0; r < MAX_KERNEL_SIDE - 1; r++) begin
            n_win[r][MAX_KERNEL_SIDE-1] = lines_old[MAX_KERNEL_SIDE-2-r];
        end
        n_win[MAX_KERNEL_SIDE-1][MAX_KERNEL_SIDE-1] = r_px1;
    end

    // The pixel at (x,y) completes the window of centre (x-hi, y-hi).
    always_comb begin
        k   = k_eff(i_ksize);
        off = k >> 1;
        hi  = k - KSIZE_W'(1) - off;
        tx  = {1'b0, r_x1} + XW'(off) - XW'(hi);
        ty  = {1'b0, r_y1} + YW'(off) - YW'(hi);
        cx  = r_x1 - COL_W'(hi);
        cy  = r_y1 - ROW_W'(hi);
        has_res = ({1'b0, r_x1} + XW'(1) >= XW'(k)) && ({1'b0, r_y1} + YW'(1) >= YW'(k))
                  && (tx < XW'(IMAGE_WIDTH)) && (ty < YW'(IMAGE_HEIGHT));
        n_meta.cx   = COORD_W'(cx);
        n_meta.cy   = COORD_W'(cy);
        n_meta.last = (tx == XW'(IMAGE_WIDTH - 1)) && (ty == YW'(IMAGE_HEIGHT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en1) begin
            r_v2 <= has_res;
        end else if (i_mac_ready) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_win   <= n_win;
            r_meta2 <= n_meta;
        end
    end

    assign o_s2 = '{valid: r_v2, meta: r_meta2, win: r_win};

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("window stage stalls input while empty");

    a_window_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !i_mac_ready |=> r_v2 && $stable(r_win))
        else $error("window changed while its result was waiting");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_x1 < COL_W'(IMAGE_WIDTH))
        else $error("column position out of range");

endmodule

// ----- rtl/core/ic2d_mac.sv -----
// Parallel window multiply, row adder stage, final adder and output register.
// Depends on ic2d_pkg.
module ic2d_mac import ic2d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_win_item i_s2,
    input  t_cfg      i_cfg,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    localparam int M = MAX_KERNEL_SIDE;

    logic signed [PROD_W-1:0] r_prod [M][M];
    logic signed [PROD_W-1:0] n_prod [M][M];
    logic signed [ROW_SUM_W-1:0] r_rsum [M];
    logic signed [ROW_SUM_W-1:0] n_rsum [M];
    logic signed [SUM_W-1:0]     n_sum;
    t_meta     r_m3, r_m4;
    logic      r_v3, r_v4, r_ov;
    t_out_item r_out;
    logic      rdy3, rdy4, rdy_out;

    assign rdy_out = !r_ov || !i_stall;
    assign rdy4    = !r_v4 || rdy_out;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;

    // The kernel sits in the lower right corner of the window; the other
    // cells contribute nothing.
    always_comb begin
        logic [KSIZE_W-1:0]       base;
        logic signed [COEF_W-1:0] coef;
        base = KSIZE_W'(M) - k_eff(i_cfg.ksize);
        coef = '0;
        for (int r = 0; r < M; r++) begin
            for (int c = 0; c < M; c++) begin
                if (KSIZE_W'(r) >= base && KSIZE_W'(c) >= base) begin
                    coef = i_cfg.rows[KSIZE_W'(r) - base][KSIZE_W'(c) - base];
                    n_prod[r][c] = $signed({1'b0, i_s2.win[r][c]}) * coef;
                end else begin
                    n_prod[r][c] = '0;
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < M; r++) begin
            n_rsum[r] = '0;
            for (int c = 0; c < M; c++) begin
                n_rsum[r] = n_rsum[r] + ROW_SUM_W'(r_prod[r][c]);
            end
        end
        n_sum = '0;
        for (int r = 0; r < M; r++) begin
            n_sum = n_sum + SUM_W'(r_rsum[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy3) begin
                r_v3 <= i_s2.valid;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy_out) begin
                r_ov <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_prod <= n_prod;
            r_m3   <= i_s2.meta;
        end
        if (rdy4) begin
            r_rsum <= n_rsum;
            r_m4   <= r_m3;
        end
        if (rdy_out) begin
            r_out.filtered_value <= n_sum;
            r_out.centre_column  <= r_m4.cx;
            r_out.centre_row     <= r_m4.cy;
            r_out.frame_last     <= r_m4.last;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    a_take_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s2.valid && o_ready |=> r_v3)
        else $error("window transfer lost at the multiply stage");

    a_row_stage_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_v4 |=> r_v4)
        else $error("products did not move into an empty adder stage");

    a_row_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_ov && i_stall |=> r_v4 && $stable(r_m4))
        else $error("adder stage lost its item behind a stalled output");

endmodule

// ----- rtl/core/image_convolution_2d.sv -----
// Streaming KxK convolution, K up to 7, one 8-bit pixel per cycle in raster order while not stalled.
// Registers from pixel to result: input, window, products, row sums, output.
// Throughput: one pixel per cycle while not stalled, set by 49 parallel multipliers and two adder stages.
// Reset: position, valid bits, K = 3 and zero coefficients; the line store RAM
// is not cleared and needs no clearing pass.
// Depends on ic2d_pkg, ic2d_cfg, ic2d_window, ic2d_mac and ic2d_ram.
module image_convolution_2d import ic2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    t_cfg      cfg;
    t_win_item s2;
    logic      mac_ready;

    ic2d_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ic2d_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_item      (i_in_item),
        .o_stall     (o_in_stall),
        .i_ksize     (cfg.ksize),
        .o_s2        (s2),
        .i_mac_ready (mac_ready)
    );

    ic2d_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (s2),
        .i_cfg   (cfg),
        .o_ready (mac_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

// ----- sim/image_convolution_2d_tb.sv -----
// Testbench for image_convolution_2d: streams frames under random idling on both channels,
// predicts each window sum on its own and checks every result transfer in order.
// Depends on ic2d_pkg and the image_convolution_2d RTL.
`timescale 1ns / 100ps

module image_convolution_2d_tb import ic2d_pkg::*; ();

    // Tracks pixel position, line store and window of the block, and keeps the window
    // sums that accepted pixels must produce, oldest first.
    class window_sum_board;
        bit [PIX_W-1:0]     line_mem [LINE_ROWS][IMAGE_WIDTH];
        bit [PIX_W-1:0]     win [MAX_KERNEL_SIDE][MAX_KERNEL_SIDE];
        int unsigned        col_pos;
        int unsigned        row_pos;
        logic [KSIZE_W-1:0] ksize;
        t_krow              coef_rows [NUM_ROW_REGS];
        t_out_item          pending_sums [$];
        int                 fail_count;

        function new();
            ksize = KSIZE_RESET;
            foreach (coef_rows[i]) coef_rows[i] = '0;
            col_pos = 0;
            row_pos = 0;
            fail_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_KSIZE) begin
                ksize = data[KSIZE_W-1:0];
            end else begin
                coef_rows[int'(idx) - int'(CFG_ROW0)] = data;
            end
        endfunction

        function void take_pixel(t_in_item it);
            int unsigned x, y, k, off, hi, cx, cy;
            int          sum;
            t_out_item   res;
            if (it.frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            x = col_pos;
            y = row_pos;

            for (int r = 0; r < MAX_KERNEL_SIDE; r++) begin
                for (int c = 0; c < MAX_KERNEL_SIDE - 1; c++) begin
                    win[r][c] = win[r][c + 1];
                end
            end
            for (int r = 0; r < LINE_ROWS; r++) begin
                win[r][MAX_KERNEL_SIDE - 1] = line_mem[LINE_ROWS - 1 - r][x];
            end
            win[MAX_KERNEL_SIDE - 1][MAX_KERNEL_SIDE - 1] = it.pixel_value;
            for (int r = LINE_ROWS - 1; r >= 1; r--) begin
                line_mem[r][x] = line_mem[r - 1][x];
            end
            line_mem[0][x] = it.pixel_value;

            k = ksize;
            if (k == 0) k = 1;
            if (k > MAX_KERNEL_SIDE) k = MAX_KERNEL_SIDE;
            off = k / 2;
            hi = k - 1 - off;

            // An even kernel reaches one column and row further left and up than right
            // and down, so its last column and row of centres fall outside the frame.
            if (x + 1 >= k && y + 1 >= k) begin
                cx = x - hi;
                cy = y - hi;
                if (cx + off < IMAGE_WIDTH && cy + off < IMAGE_HEIGHT) begin
                    sum = 0;
                    for (int ky = 0; ky < k; ky++) begin
                        for (int kx = 0; kx < k; kx++) begin
                            sum += int'(win[MAX_KERNEL_SIDE - k + ky][MAX_KERNEL_SIDE - k + kx])
                                 * int'($signed(coef_rows[ky][kx]));
                        end
                    end
                    res.filtered_value = sum[SUM_W-1:0];
                    res.centre_column  = cx[COORD_W-1:0];
                    res.centre_row     = cy[COORD_W-1:0];
                    res.frame_last     = (cx + off + 1 == IMAGE_WIDTH)
                                      && (cy + off + 1 == IMAGE_HEIGHT);
                    pending_sums.push_back(res);
                end
            end

            x++;
            if (x >= IMAGE_WIDTH) begin
                x = 0;
                y++;
                if (y >= IMAGE_HEIGHT) y = 0;
            end
            col_pos = x;
            row_pos = y;
        endfunction

        function void flag(string field, logic signed [31:0] want, logic signed [31:0] got);
            fail_count++;
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_sums.size() == 0) begin
                fail_count++;
                $error("result with no pixel behind it: value %0d at column %0d row %0d",
                       got.filtered_value, got.centre_column, got.centre_row);
                return;
            end
            want = pending_sums.pop_front();
            if (got.filtered_value !== want.filtered_value)
                flag("filtered_value", want.filtered_value, got.filtered_value);
            if (got.centre_column !== want.centre_column)
                flag("centre_column", want.centre_column, got.centre_column);
            if (got.centre_row !== want.centre_row)
                flag("centre_row", want.centre_row, got.centre_row);
            if (got.frame_last !== want.frame_last)
                flag("frame_last", want.frame_last, got.frame_last);
        endfunction

        function void close_out();
            if (pending_sums.size() != 0) begin
                fail_count++;
                $error("%0d expected results never arrived", pending_sums.size());
            end
        endfunction
    endclass

    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     DRAIN_LIMIT      = 20000;
    localparam int     PIPE_PAUSE       = 10;
    localparam longint RUN_LIMIT_NS     = 5_000_000;

    localparam logic [COEF_W-1:0] COEF_MIN_RAW = 9'h100;
    localparam logic [COEF_W-1:0] COEF_MAX_RAW = 9'h0FF;

    typedef enum {COEF_RANDOM, COEF_MOST_NEG, COEF_MOST_POS, COEF_MIXED} t_coef_style;
    typedef enum {PIX_RANDOM, PIX_BRIGHT, PIX_EXTREME} t_pix_style;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  pix_valid = 1'b0;
    t_in_item              pix_item  = '0;
    logic                  in_stall;
    logic                  res_valid;
    t_out_item             res_item;
    logic                  res_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cfg_ready;

    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    bit hold_req      = 1'b0;

    window_sum_board board;

    image_convolution_2d DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (pix_valid),
        .i_in_item   (pix_item),
        .o_in_stall  (in_stall),
        .o_out_valid (res_valid),
        .o_out_item  (res_item),
        .i_out_stall (res_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Both channels are sampled at the edge, before any driver update of that step.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pix_valid && in_stall === 1'b0) board.take_pixel(pix_item);
            if (res_valid === 1'b1 && !res_stall) board.check_result(res_item);
        end
    end

    initial begin : result_side
        int n;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 12);
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic t_krow make_row(t_coef_style cs);
        t_krow row;
        for (int c = 0; c < KROW_COEFS; c++) begin
            case (cs)
                COEF_MOST_NEG: row[c] = COEF_MIN_RAW;
                COEF_MOST_POS: row[c] = COEF_MAX_RAW;
                COEF_MIXED: begin
                    case ($urandom_range(0, 4))
                        0:       row[c] = COEF_MIN_RAW;
                        1:       row[c] = COEF_MAX_RAW;
                        2:       row[c] = '0;
                        3:       row[c] = '1;
                        default: row[c] = COEF_W'($urandom);
                    endcase
                end
                default: row[c] = COEF_W'($urandom);
            endcase
        end
        return row;
    endfunction

    function automatic logic [PIX_W-1:0] make_pixel(t_pix_style ps);
        logic [PIX_W-1:0] px;
        case (ps)
            PIX_BRIGHT:  px = '1;
            PIX_EXTREME: px = $urandom_range(0, 1) ? '1 : '0;
            default:     px = PIX_W'($urandom);
        endcase
        return px;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit first);
        int n;
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 12);
            pix_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item  <= '{pixel_value: px, frame_start: first};
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
    endtask

    // Writes the kernel size and then every coefficient row, valid held high throughout.
    task automatic load_kernel(input logic [KSIZE_W-1:0] ksz, input t_krow rows [NUM_ROW_REGS]);
        for (int i = 0; i <= NUM_ROW_REGS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            if (i == CFG_KSIZE) begin
                cfg_data <= CFG_DATA_W'(ksz);
            end else begin
                cfg_data <= rows[i - CFG_ROW0];
            end
            @(posedge clk);
            while (cfg_ready !== 1'b1) @(posedge clk);
            board.write_reg(cfg_index, cfg_data);
        end
        cfg_valid <= 1'b0;
    endtask

    // Waits for the outstanding results, then lets the pipeline run empty.
    task automatic settle();
        int waited;
        waited = 0;
        while (board.pending_sums.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (PIPE_PAUSE) @(posedge clk);
    endtask

    task automatic run_frame(input int ksz, input t_coef_style cs, input t_pix_style ps,
                             input bit aborted_start, input bit idle_on, input bit squeeze,
                             input int total);
        t_krow rows [NUM_ROW_REGS];
        int    span;
        settle();
        foreach (rows[r]) rows[r] = make_row(cs);
        load_kernel(KSIZE_W'(ksz), rows);
        sender_gaps   = idle_on;
        receiver_gaps = idle_on;
        if (squeeze) hold_req = 1'b1;
        // A frame cut short leaves stale data behind in the line store.
        if (aborted_start) begin
            span = $urandom_range(1, 20);
            for (int i = 0; i < span; i++) send_pixel(make_pixel(ps), i == 0);
        end
        for (int i = 0; i < total; i++) send_pixel(make_pixel(ps), i == 0);
        pix_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_krow rows [NUM_ROW_REGS];
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-tap kernel at the most negative coefficient, with a restart mid-stream.
        foreach (rows[r]) rows[r] = '0;
        rows[0][0] = COEF_MIN_RAW;
        load_kernel(KSIZE_W'(1), rows);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h7F, 1'b0);
        pix_valid <= 1'b0;
        settle();

        // A zero kernel size behaves as a single tap.
        rows[0][0] = COEF_MAX_RAW;
        rows[0][1] = COEF_MIN_RAW;
        load_kernel(KSIZE_W'(0), rows);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b0);
        pix_valid <= 1'b0;

        // Large kernels see too few rows here and must stay silent.
        run_frame(7, COEF_MOST_NEG, PIX_BRIGHT,  1'b0, 1'b1, 1'b0, 60);
        run_frame(1, COEF_MOST_NEG, PIX_BRIGHT,  1'b1, 1'b1, 1'b0, 100);
        run_frame(1, COEF_MOST_POS, PIX_BRIGHT,  1'b0, 1'b1, 1'b0, 100);
        run_frame(0, COEF_RANDOM,   PIX_RANDOM,  1'b0, 1'b1, 1'b1, 320);
        run_frame(1, COEF_MIXED,    PIX_EXTREME, 1'b1, 1'b1, 1'b1, 150);
        run_frame(3, COEF_RANDOM,   PIX_RANDOM,  1'b1, 1'b1, 1'b0, 60);

        // The final stretch runs with no idling on either side.
        run_frame(1, COEF_RANDOM,   PIX_RANDOM,  1'b0, 1'b0, 1'b0, 200);

        settle();
        board.close_out();
        if (board.fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
